// File: sv/gdps_pkg.sv
package gdps_pkg;

    localparam int MAX_ROWS_DEF   = 8;
    localparam int MAX_COLS_DEF   = 8;
    localparam int DEPTH_BITS_DEF = 16;

    localparam logic [2:0] REG_ROW_COUNT = 3'd0;
    localparam logic [2:0] REG_COL_COUNT = 3'd1;
    localparam logic [2:0] REG_MIN_DEPTH = 3'd2;
    localparam logic [2:0] REG_START_ROW = 3'd3;
    localparam logic [2:0] REG_START_COL = 3'd4;
    localparam logic [2:0] REG_DEST_ROW  = 3'd5;
    localparam logic [2:0] REG_DEST_COL  = 3'd6;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_VISIT,
        ST_PROBE,
        ST_CHECK,
        ST_BACK,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

endpackage

// File: sv/grid_depth_path_search_core.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  req_type, cell_row, cell_col, cell_depth
// out       output     out_valid/out_stall out_row, out_col, step_number, found, last
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load item is written straight into the depth memory while the block is idle. A
// search item first clears the step map, one cell a cycle, and then marks the start
// cell. It then walks the grid: each try of one direction chooses the neighbour,
// reads its depth and step and checks them, and each backtrack gives up the cell,
// clears it and pops the stack. The map then streams out, one result per pass
// through ST_EMIT_RD and ST_EMIT, and holds while the output stalls. Reset clears
// only the control state and the registers.
// A stalled result simply holds; the block takes no new item until the map is out.
module grid_depth_path_search_core
    import gdps_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [2:0]                   cell_row,
    input  logic [2:0]                   cell_col,
    input  logic signed [DEPTH_BITS-1:0] cell_depth,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   out_row,
    output logic [2:0]                   out_col,
    output logic [6:0]                   step_number,
    output logic                         found,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);

    // The fields are three bits wide, so only cells up to 8 x 8 are reachable.
    localparam int RL    = (MAX_ROWS < 8) ? MAX_ROWS : 8;
    localparam int CL    = (MAX_COLS < 8) ? MAX_COLS : 8;
    localparam int CELLS = 64;

    logic [3:0]                   row_count_reg, col_count_reg;
    logic signed [DEPTH_BITS-1:0] min_depth_reg;
    logic [2:0]                   start_row_reg, start_col_reg, dest_row_reg, dest_col_reg;

    // Memories: depth and step are addressed {row, col}, the path stack by its pointer.
    logic signed [DEPTH_BITS-1:0] depth_mem [CELLS];
    logic [6:0]                   step_mem  [CELLS];
    logic [1:0]                   dir_mem   [CELLS];
    logic [2:0]                   prow_mem  [CELLS];
    logic [2:0]                   pcol_mem  [CELLS];

    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [5:0] sp_reg, sp_next;
    logic [2:0] cr_reg, cr_next, cc_reg, cc_next;
    logic [2:0] nr_reg, nr_next, nc_reg, nc_next;
    logic [2:0] dir_reg, dir_next;
    logic       nok_reg, nok_next;
    logic       found_reg, found_next;
    logic [3:0] rows, cols;

    logic signed [DEPTH_BITS-1:0] depth_rd;
    logic [6:0] step_rd;
    logic [1:0] dir_rd;
    logic [2:0] prow_rd, pcol_rd;

    logic [5:0] d_addr, s_addr, s_waddr, k_addr;
    logic       s_we, k_we;
    logic [6:0] s_wdata;

    logic        o_valid_reg;
    logic [2:0]  o_row_reg, o_col_reg;
    logic [6:0]  o_step_reg;
    logic        o_found_reg, o_last_reg;
    logic [2:0]  er_reg, er_next, ec_reg, ec_next;
    logic        o_load;

    always_comb
    begin
        rows = (row_count_reg == 4'd0) ? 4'd1 :
               (row_count_reg > 4'(RL)) ? 4'(RL) : row_count_reg;
        cols = (col_count_reg == 4'd0) ? 4'd1 :
               (col_count_reg > 4'(CL)) ? 4'(CL) : col_count_reg;
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 4'd8;
            col_count_reg <= 4'd8;
            min_depth_reg <= '0;
            start_row_reg <= '0;
            start_col_reg <= '0;
            dest_row_reg  <= '0;
            dest_col_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data[3:0];
                REG_COL_COUNT: col_count_reg <= cfg_data[3:0];
                REG_MIN_DEPTH: min_depth_reg <= DEPTH_BITS'(signed'(cfg_data));
                REG_START_ROW: start_row_reg <= cfg_data[2:0];
                REG_START_COL: start_col_reg <= cfg_data[2:0];
                REG_DEST_ROW:  dest_row_reg  <= cfg_data[2:0];
                REG_DEST_COL:  dest_col_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Depth memory: written by loads, read at the probed neighbour.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !req_type
            && 32'(cell_row) < RL && 32'(cell_col) < CL)
            depth_mem[{cell_row, cell_col}] <= cell_depth;
        depth_rd <= depth_mem[d_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            step_mem[s_waddr] <= s_wdata;
        step_rd <= step_mem[s_addr];
    end

    // Path stack: direction taken and the cell it was taken from.
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            dir_mem[k_addr]  <= dir_reg[1:0];
            prow_mem[k_addr] <= cr_reg;
            pcol_mem[k_addr] <= cc_reg;
        end
        dir_rd  <= dir_mem[k_addr];
        prow_rd <= prow_mem[k_addr];
        pcol_rd <= pcol_mem[k_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sp_reg    <= '0;
            cr_reg    <= '0;
            cc_reg    <= '0;
            nr_reg    <= '0;
            nc_reg    <= '0;
            dir_reg   <= '0;
            nok_reg   <= 1'b0;
            found_reg <= 1'b0;
            er_reg    <= '0;
            ec_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sp_reg    <= sp_next;
            cr_reg    <= cr_next;
            cc_reg    <= cc_next;
            nr_reg    <= nr_next;
            nc_reg    <= nc_next;
            dir_reg   <= dir_next;
            nok_reg   <= nok_next;
            found_reg <= found_next;
            er_reg    <= er_next;
            ec_reg    <= ec_next;
        end
    end

    function automatic logic o_last_reg_next();
        o_last_reg_next = ({1'b0, er_reg} == rows - 4'd1) && ({1'b0, ec_reg} == cols - 4'd1);
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && req_type)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                if (cnt_reg == 7'(CELLS))
                    state_next = ({1'b0, start_row_reg} < rows && {1'b0, start_col_reg} < cols)
                                 ? ST_VISIT : ST_EMIT_RD;
            ST_VISIT:
                if (dir_reg == 3'd0 && cr_reg == dest_row_reg && cc_reg == dest_col_reg)
                    state_next = ST_EMIT_RD;
                else if (dir_reg[2])
                    state_next = ST_BACK;
                else
                    state_next = ST_PROBE;
            ST_PROBE:  state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_VISIT;
            ST_BACK:   state_next = (sp_reg == 6'd0) ? ST_EMIT_RD : ST_POP;
            ST_POP:    state_next = ST_VISIT;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
                if (o_load)
                    state_next = (o_last_reg_next()) ? ST_IDLE : ST_EMIT_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        logic [3:0] tr, tc;
        logic       inside_g;
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        cr_next    = cr_reg;
        cc_next    = cc_reg;
        nr_next    = nr_reg;
        nc_next    = nc_reg;
        dir_next   = dir_reg;
        nok_next   = nok_reg;
        found_next = found_reg;
        er_next    = er_reg;
        ec_next    = ec_reg;
        d_addr     = {nr_reg, nc_reg};
        s_addr     = {nr_reg, nc_reg};
        s_waddr    = {cr_reg, cc_reg};
        s_we       = 1'b0;
        s_wdata    = '0;
        k_addr     = sp_reg;
        k_we       = 1'b0;
        o_load     = 1'b0;
        tr         = {1'b0, cr_reg};
        tc         = {1'b0, cc_reg};
        inside_g   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
            end
            ST_CLEAR:
            begin
                s_we     = 1'b1;
                s_waddr  = cnt_reg[5:0];
                cnt_next = cnt_reg + 7'd1;
                sp_next  = '0;
                cr_next  = start_row_reg;
                cc_next  = start_col_reg;
                dir_next = '0;
                er_next  = '0;
                ec_next  = '0;
                if (cnt_reg == 7'(CELLS))
                begin
                    // The start cell is step 1 whatever its depth, if it lies inside the grid.
                    s_waddr = {start_row_reg, start_col_reg};
                    s_wdata = ({1'b0, start_row_reg} < rows && {1'b0, start_col_reg} < cols)
                              ? 7'd1 : 7'd0;
                end
            end
            ST_VISIT:
            begin
                if (dir_reg == 3'd0 && cr_reg == dest_row_reg && cc_reg == dest_col_reg)
                    found_next = 1'b1;
                unique case (dir_reg[1:0])
                    DIR_UP:    tr = {1'b0, cr_reg} - 4'd1;
                    DIR_RIGHT: tc = {1'b0, cc_reg} + 4'd1;
                    DIR_DOWN:  tr = {1'b0, cr_reg} + 4'd1;
                    DIR_LEFT:  tc = {1'b0, cc_reg} - 4'd1;
                    default: ;
                endcase
                inside_g = (tr < rows) && (tc < cols) && (sp_reg != 6'(CELLS - 1));
                nok_next = inside_g;
                nr_next  = tr[2:0];
                nc_next  = tc[2:0];
            end
            ST_PROBE: ;
            ST_CHECK:
            begin
                if (nok_reg && depth_rd > min_depth_reg && step_rd == 7'd0)
                begin
                    k_we     = 1'b1;
                    sp_next  = sp_reg + 6'd1;
                    s_we     = 1'b1;
                    s_waddr  = {nr_reg, nc_reg};
                    s_wdata  = {1'b0, sp_reg} + 7'd2;
                    cr_next  = nr_reg;
                    cc_next  = nc_reg;
                    dir_next = '0;
                end
                else
                    dir_next = dir_reg + 3'd1;
            end
            ST_BACK:
            begin
                s_we    = 1'b1;
                s_wdata = '0;
                k_addr  = sp_reg - 6'd1;
                if (sp_reg != 6'd0)
                    sp_next = sp_reg - 6'd1;
            end
            ST_POP:
            begin
                cr_next  = prow_rd;
                cc_next  = pcol_rd;
                dir_next = {1'b0, dir_rd} + 3'd1;
            end
            ST_EMIT_RD:
                s_addr = {er_reg, ec_reg};
            ST_EMIT:
            begin
                s_addr = {er_reg, ec_reg};
                o_load = !o_valid_reg || !out_stall;
                if (o_load)
                begin
                    if ({1'b0, ec_reg} == cols - 4'd1)
                    begin
                        ec_next = '0;
                        er_next = er_reg + 3'd1;
                    end
                    else
                        ec_next = ec_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_load)
            o_valid_reg <= 1'b1;
        else if (!out_stall)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_row_reg   <= er_reg;
            o_col_reg   <= ec_reg;
            o_step_reg  <= step_rd;
            o_found_reg <= found_reg;
            o_last_reg  <= o_last_reg_next();
        end
    end

    assign out_valid   = o_valid_reg;
    assign out_row     = o_row_reg;
    assign out_col     = o_col_reg;
    assign step_number = o_step_reg;
    assign found       = o_found_reg;
    assign last        = o_last_reg;

endmodule

// File: tb/grid_depth_path_search_core_tb.sv
`timescale 1ns / 1ps

module grid_depth_path_search_core_tb;
    import gdps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    // Longest walk, in block cycles, that a random search is allowed to take.
    localparam int SEARCH_BUDGET  = 3000;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  cell_row;
        logic [2:0]  cell_col;
        logic [15:0] cell_depth;
    } grid_req_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [6:0] step;
        logic       found;
        logic       last;
    } map_cell_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [2:0]  cell_row;
    logic [2:0]  cell_col;
    logic signed [15:0] cell_depth;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [6:0]  step_number;
    logic        found;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    grid_depth_path_search_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .cell_row(cell_row), .cell_col(cell_col),
        .cell_depth(cell_depth),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_row(out_row), .out_col(out_col), .step_number(step_number),
        .found(found), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // The predictor's own copy of the grid and the registers.
    logic signed [15:0] grid_depth [64];
    logic [3:0]         rows_reg, cols_reg;
    logic signed [15:0] depth_floor;
    logic [2:0]         origin_row, origin_col, target_row, target_col;

    grid_req_t pending_reqs [$];
    map_cell_t expected_map [$];
    int        mismatches;
    int        idle_cycles;
    int        send_gap;
    int        stall_left;
    int        walk_cost;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // Walks the grid as the block does. A real run queues the map it should
    // stream out; a dry run only counts the walk's cycles and gives up once
    // they pass the budget.
    task automatic predict_search(input bit dry_run, output int cost);
        logic [6:0] steps [64];
        int  trail_r [64];
        int  trail_c [64];
        int  heading [64];
        int  rows, cols, depth_sp, first_dir, nr, nc, d, total, n;
        bit  hit, moved;
        rows = (rows_reg == 0) ? 1 : (rows_reg > 8 ? 8 : rows_reg);
        cols = (cols_reg == 0) ? 1 : (cols_reg > 8 ? 8 : cols_reg);
        hit = 0;
        depth_sp = 0;
        first_dir = 0;
        cost = 0;
        foreach (steps[i]) steps[i] = '0;
        if (origin_row < rows && origin_col < cols)
        begin
            trail_r[0] = origin_row;
            trail_c[0] = origin_col;
            steps[origin_row * 8 + origin_col] = 7'd1;
            forever
            begin
                if (dry_run && cost > SEARCH_BUDGET) break;
                if (first_dir == 0 && trail_r[depth_sp] == target_row
                    && trail_c[depth_sp] == target_col)
                begin
                    hit = 1;
                    cost += 1;
                    break;
                end
                moved = 0;
                for (d = first_dir; d < 4; d++)
                begin
                    cost += 3;
                    nr = trail_r[depth_sp];
                    nc = trail_c[depth_sp];
                    case (d)
                        DIR_UP:    nr--;
                        DIR_RIGHT: nc++;
                        DIR_DOWN:  nr++;
                        default:   nc--;
                    endcase
                    if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                    if (grid_depth[nr * 8 + nc] <= depth_floor) continue;
                    if (steps[nr * 8 + nc] != 0) continue;
                    if (depth_sp + 1 >= 64) continue;
                    heading[depth_sp] = d;
                    depth_sp++;
                    trail_r[depth_sp] = nr;
                    trail_c[depth_sp] = nc;
                    steps[nr * 8 + nc] = 7'(depth_sp + 1);
                    moved = 1;
                    break;
                end
                if (moved)
                begin
                    first_dir = 0;
                    continue;
                end
                cost += 2;
                steps[trail_r[depth_sp] * 8 + trail_c[depth_sp]] = '0;
                if (depth_sp == 0) break;
                cost += 1;
                depth_sp--;
                first_dir = heading[depth_sp] + 1;
            end
        end
        if (!dry_run)
        begin
            total = rows * cols;
            n = 0;
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                begin
                    n++;
                    expected_map.push_back('{row: 3'(r), col: 3'(c), step: steps[r * 8 + c],
                                             found: hit, last: (n == total)});
                end
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            REG_ROW_COUNT: rows_reg    = value[3:0];
            REG_COL_COUNT: cols_reg    = value[3:0];
            REG_MIN_DEPTH: depth_floor = value;
            REG_START_ROW: origin_row  = value[2:0];
            REG_START_COL: origin_col  = value[2:0];
            REG_DEST_ROW:  target_row  = value[2:0];
            default:       target_col  = value[2:0];
        endcase
    endtask

    task automatic queue_load(input int r, input int c, input logic [15:0] dep);
        pending_reqs.push_back('{req_type: 1'b0, cell_row: 3'(r), cell_col: 3'(c),
                                 cell_depth: dep});
    endtask

    task automatic queue_search();
        pending_reqs.push_back('{req_type: 1'b1, cell_row: 3'($urandom),
                                 cell_col: 3'($urandom), cell_depth: 16'($urandom)});
    endtask

    // Lets the queued items drain and every map come out before registers change.
    // The queues are looked at on the falling edge, once the driver has settled.
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_map.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Driver: takes items off the pending queue, with a random gap before each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            // The accepted item is predicted here, in the order the block takes it.
            if (req_type == 1'b0)
                grid_depth[cell_row * 8 + cell_col] = cell_depth;
            else
                predict_search(1'b0, walk_cost);
            in_valid <= 1'b0;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_reqs.size() != 0)
            begin
                grid_req_t nxt;
                nxt = pending_reqs.pop_front();
                in_valid   <= 1'b1;
                req_type   <= nxt.req_type;
                cell_row   <= nxt.cell_row;
                cell_col   <= nxt.cell_col;
                cell_depth <= nxt.cell_depth;
            end
        end
    end

    // Monitor: checks each result against the oldest expected map cell.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_map.size() == 0)
                    report_mismatch($sformatf("unexpected result row %0d col %0d",
                                              out_row, out_col));
                else
                begin
                    map_cell_t exp_cell;
                    exp_cell = expected_map.pop_front();
                    if (out_row !== exp_cell.row)
                        report_mismatch($sformatf("out_row %0d, want %0d", out_row,
                                                  exp_cell.row));
                    if (out_col !== exp_cell.col)
                        report_mismatch($sformatf("out_col %0d, want %0d", out_col,
                                                  exp_cell.col));
                    if (step_number !== exp_cell.step)
                        report_mismatch($sformatf("step_number %0d, want %0d at %0d,%0d",
                                                  step_number, exp_cell.step,
                                                  exp_cell.row, exp_cell.col));
                    if (found !== exp_cell.found)
                        report_mismatch($sformatf("found %0b, want %0b", found,
                                                  exp_cell.found));
                    if (last !== exp_cell.last)
                        report_mismatch($sformatf("last %0b, want %0b", last,
                                                  exp_cell.last));
                end
            end
            // The stall draws a fresh length each time a result gets through.
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            end
        end
    end

    // Watchdog: a long spell with nothing accepted means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || pending_reqs.size() == 0 && expected_map.size() == 0 && !in_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[grid_depth_path_search_core] ERROR");
            $finish;
        end
    end

    // Fills the whole 8x8 grid with depths; a fraction of cells is made
    // impassable against the current floor so that the walk must backtrack.
    task automatic fill_grid(input int wall_pct);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
            begin
                logic [15:0] dep;
                if ($urandom_range(0, 99) < wall_pct)
                    dep = (depth_floor == -32768) ? 16'sh8000
                          : 16'(depth_floor - $urandom_range(0, 50));
                else
                    dep = (depth_floor == 32767) ? 16'sh7fff
                          : 16'(depth_floor + 1 + $urandom_range(0, 50));
                queue_load(r, c, dep);
            end
    endtask

    initial
    begin
        int searches;
        int cost;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = 1'b0;
        cell_row   = '0;
        cell_col   = '0;
        cell_depth = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_ROW_COUNT;
        cfg_data   = '0;
        mismatches = 0;
        idle_cycles = 0;
        rows_reg = 4'd8;
        cols_reg = 4'd8;
        depth_floor = '0;
        origin_row = '0;
        origin_col = '0;
        target_row = '0;
        target_col = '0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;

        // Directed part: every cell is loaded before any search, so no search
        // ever reads a cell that was never written. Extreme depths go in first.
        queue_load(0, 0, 16'sh8000);
        queue_load(7, 7, 16'sh7fff);
        queue_load(3, 5, 16'hffff);
        queue_load(5, 2, 16'h0001);
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                if (!((r == 0 && c == 0) || (r == 7 && c == 7)))
                    queue_load(r, c, 16'(1 + r + c));
        // Reset registers: start equals destination, found on the first cell,
        // and the start cell joins the path though its depth is the minimum.
        queue_search();
        drain();
        // Full grid to the far corner, along a path through passable cells.
        write_reg(REG_DEST_ROW, 16'd7);
        write_reg(REG_DEST_COL, 16'd7);
        queue_search();
        drain();
        // Highest floor: nothing passable, no path.
        write_reg(REG_MIN_DEPTH, 16'sh7fff);
        queue_search();
        drain();
        // Lowest floor with a one-row grid; out-of-range sizes clamp.
        write_reg(REG_MIN_DEPTH, 16'sh8000);
        write_reg(REG_ROW_COUNT, 16'd0);
        write_reg(REG_COL_COUNT, 16'd15);
        queue_search();
        drain();
        // Start outside the grid in use, destination outside too.
        write_reg(REG_ROW_COUNT, 16'd3);
        write_reg(REG_COL_COUNT, 16'd1);
        write_reg(REG_START_ROW, 16'd5);
        write_reg(REG_START_COL, 16'd7);
        queue_search();
        drain();
        write_reg(REG_START_ROW, 16'd0);
        write_reg(REG_START_COL, 16'd0);
        queue_search();
        drain();

        // Random part: phases of new registers, a refilled grid and searches.
        searches = 0;
        while (searches < 28)
        begin
            write_reg(REG_ROW_COUNT, ($urandom_range(0, 4) == 0)
                      ? 16'($urandom_range(0, 15)) : 16'($urandom_range(1, 8)));
            write_reg(REG_COL_COUNT, ($urandom_range(0, 4) == 0)
                      ? 16'($urandom_range(0, 15)) : 16'($urandom_range(1, 8)));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_MIN_DEPTH, 16'sh8000);
                1:       write_reg(REG_MIN_DEPTH, 16'sh7fff);
                2:       write_reg(REG_MIN_DEPTH, 16'($urandom));
                default: write_reg(REG_MIN_DEPTH, 16'($urandom_range(0, 200) - 100));
            endcase
            write_reg(REG_START_ROW, 16'($urandom_range(0, 7)));
            write_reg(REG_START_COL, 16'($urandom_range(0, 7)));
            write_reg(REG_DEST_ROW, 16'($urandom_range(0, 7)));
            write_reg(REG_DEST_COL, 16'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0)
                fill_grid($urandom_range(10, 45));
            else
                for (int k = 0; k < $urandom_range(1, 6); k++)
                    queue_load($urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
            drain();
            // An open grid can take exponentially long to search exhaustively;
            // such a walk is cut short by aiming at the start cell instead.
            predict_search(1'b1, cost);
            if (cost > SEARCH_BUDGET)
            begin
                write_reg(REG_DEST_ROW, 16'(origin_row));
                write_reg(REG_DEST_COL, 16'(origin_col));
            end
            for (int k = 0; k < $urandom_range(1, 3); k++)
            begin
                queue_search();
                searches++;
            end
            drain();
        end

        drain();
        if (mismatches == 0)
            $display("[grid_depth_path_search_core] OK");
        else
            $display("[grid_depth_path_search_core] ERROR");
        $finish;
    end

endmodule
